FILE: sv/assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MSC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

`define MSC_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define MSC_ASSERT(lbl, clk, rstn, prop)

`define MSC_ASSERT_NORST(lbl, clk, prop)

`endif

`endif

FILE: sv/msc_pkg.sv
`timescale 1ns / 1ps

package msc_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int ID_WIDTH        = 31;
  localparam int AGE_WIDTH       = 16;
  localparam int OUT_CNT_WIDTH   = 32;
  localparam int MODE_WIDTH      = 2;
  localparam int CFG_IDX_WIDTH   = 1;
  localparam int CFG_DATA_WIDTH  = 16;

  // bitmap cost: (id / 32 + 1) * 4
  localparam int BMP_SHIFT  = 5;
  localparam int BMP_IDX_W  = ID_WIDTH - BMP_SHIFT + 1;
  localparam int BMP_COST_W = BMP_IDX_W + 2;

  localparam logic [MODE_WIDTH-1:0] MODE_GT = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_EQ = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_LT = 2'd2;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_COMPARE_MODE  = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_AGE_THRESHOLD = 1'b1;

  typedef enum logic [1:0] {
    KIND_ARRAY  = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_BITMAP = 2'd2
  } kind_t;

endpackage

FILE: sv/msc_cost_select.sv
`timescale 1ns / 1ps

module msc_cost_select #(
  parameter int COUNT_WIDTH = msc_pkg::COUNT_WIDTH_DEF
) (
  input  logic [COUNT_WIDTH-1:0]       match_cnt,
  input  logic [COUNT_WIDTH-1:0]       run_cnt,
  input  logic [msc_pkg::ID_WIDTH-1:0] largest_id,
  input  logic                         seen,
  output msc_pkg::kind_t               kind
);

  localparam int CMP_W = (COUNT_WIDTH + 3 > msc_pkg::BMP_COST_W) ?
                         COUNT_WIDTH + 3 : msc_pkg::BMP_COST_W;

  logic [msc_pkg::BMP_IDX_W-1:0] bmp_words;
  logic [CMP_W-1:0]              cost_array;
  logic [CMP_W-1:0]              cost_run;
  logic [CMP_W-1:0]              cost_bitmap;
  logic                          a_le_b;
  logic                          a_le_r;
  logic                          r_le_b;
  logic                          r_le_a;

  assign bmp_words   = msc_pkg::BMP_IDX_W'(largest_id >> msc_pkg::BMP_SHIFT) +
                       msc_pkg::BMP_IDX_W'(1);
  assign cost_array  = CMP_W'({match_cnt, 2'b00});
  assign cost_run    = CMP_W'({run_cnt, 3'b000});
  assign cost_bitmap = CMP_W'({bmp_words, 2'b00});

  // bitmap is unbounded when nothing matched
  assign a_le_b = !seen || (cost_array <= cost_bitmap);
  assign a_le_r = cost_array <= cost_run;
  assign r_le_b = !seen || (cost_run <= cost_bitmap);
  assign r_le_a = cost_run <= cost_array;

  always_comb begin
    if (a_le_b && a_le_r) begin
      kind = msc_pkg::KIND_ARRAY;
    end else if (r_le_b && r_le_a) begin
      kind = msc_pkg::KIND_RUN;
    end else begin
      kind = msc_pkg::KIND_BITMAP;
    end
  end

endmodule

FILE: sv/match_set_container_selector_unit.sv
// match set container selector
// input channel: in_valid/in_ready carry one record (in_user_id, in_age_days,
// in_last_record). a record matches when its age compares against the
// threshold under the compare mode (greater, equal, less; mode 3 never hits).
// match count, run count, first and largest matching id are kept per data
// set; the counters saturate at 2^COUNT_WIDTH - 1.
// output channel: out_valid/out_ready carry one result per data set, on the
// record marked last: the cheapest container (array, run, bitmap, ties to
// array then run) with the statistics; statistics then clear.
// config port: cfg_we writes cfg_wdata to register cfg_index at once
// (0 compare mode, 1 age threshold); write only while idle.
// a record is registered on transfer; when the last record leaves the record
// register, its result goes into the output register and out_valid rises,
// unless a result is pending unread. throughput: one record per cycle while no
// last record waits, set by the single record register ahead of the
// statistics update. when the receiver stalls with a result pending, non-last
// records keep flowing; a following last record waits in the record register.
// reset (rst_n low, synchronous) clears statistics, both config registers,
// and the valid flags; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module match_set_container_selector_unit #(
  parameter int COUNT_WIDTH = msc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [msc_pkg::ID_WIDTH-1:0]         in_user_id,
  input  logic [msc_pkg::AGE_WIDTH-1:0]        in_age_days,
  input  logic                                 in_last_record,

  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_container_kind,
  output logic [msc_pkg::OUT_CNT_WIDTH-1:0]    out_match_total,
  output logic [msc_pkg::OUT_CNT_WIDTH-1:0]    out_run_total,
  output logic [msc_pkg::ID_WIDTH-1:0]         out_first_match_id,
  output logic [msc_pkg::ID_WIDTH-1:0]         out_largest_match_id,
  output logic                                 out_any_match,

  input  logic                                 cfg_we,
  input  logic [msc_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [msc_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // configuration
  logic [msc_pkg::MODE_WIDTH-1:0] mode_r;
  logic [msc_pkg::AGE_WIDTH-1:0]  thresh_r;

  // record register
  logic                           s1_valid_r;
  logic [msc_pkg::ID_WIDTH-1:0]   s1_id_r;
  logic [msc_pkg::AGE_WIDTH-1:0]  s1_age_r;
  logic                           s1_last_r;

  // statistics
  logic [COUNT_WIDTH-1:0]         match_cnt_r;
  logic [COUNT_WIDTH-1:0]         run_cnt_r;
  logic                           prev_hit_r;
  logic [msc_pkg::ID_WIDTH-1:0]   first_id_r;
  logic [msc_pkg::ID_WIDTH-1:0]   largest_id_r;
  logic                           seen_r;

  // result register
  logic                           out_valid_r;
  msc_pkg::kind_t                 kind_r;
  logic [msc_pkg::OUT_CNT_WIDTH-1:0] match_tot_r;
  logic [msc_pkg::OUT_CNT_WIDTH-1:0] run_tot_r;
  logic [msc_pkg::ID_WIDTH-1:0]   out_first_r;
  logic [msc_pkg::ID_WIDTH-1:0]   out_largest_r;
  logic                           out_any_r;

  logic                           s1_go;
  logic                           hit;
  logic [COUNT_WIDTH-1:0]         match_cnt_nxt;
  logic [COUNT_WIDTH-1:0]         run_cnt_nxt;
  logic [msc_pkg::ID_WIDTH-1:0]   first_id_nxt;
  logic [msc_pkg::ID_WIDTH-1:0]   largest_id_nxt;
  logic                           seen_nxt;
  logic [msc_pkg::OUT_CNT_WIDTH-1:0] match_tot_nxt;
  logic [msc_pkg::OUT_CNT_WIDTH-1:0] run_tot_nxt;
  msc_pkg::kind_t                 kind_nxt;

  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_comb begin
    unique case (mode_r)
      msc_pkg::MODE_GT: hit = s1_age_r > thresh_r;
      msc_pkg::MODE_EQ: hit = s1_age_r == thresh_r;
      msc_pkg::MODE_LT: hit = s1_age_r < thresh_r;
      default:          hit = 1'b0;
    endcase
  end

  // statistics including the record in the register
  always_comb begin
    match_cnt_nxt  = match_cnt_r;
    run_cnt_nxt    = run_cnt_r;
    first_id_nxt   = first_id_r;
    largest_id_nxt = largest_id_r;
    if (hit) begin
      if (match_cnt_r != CNT_MAX) begin
        match_cnt_nxt = match_cnt_r + COUNT_WIDTH'(1);
      end
      if (!prev_hit_r && (run_cnt_r != CNT_MAX)) begin
        run_cnt_nxt = run_cnt_r + COUNT_WIDTH'(1);
      end
      if (!seen_r) begin
        first_id_nxt = s1_id_r;
      end
      if (!seen_r || (s1_id_r > largest_id_r)) begin
        largest_id_nxt = s1_id_r;
      end
    end
  end

  assign seen_nxt = seen_r || hit;

  generate
    if (COUNT_WIDTH > msc_pkg::OUT_CNT_WIDTH) begin : g_clamp
      assign match_tot_nxt = (|match_cnt_nxt[COUNT_WIDTH-1:msc_pkg::OUT_CNT_WIDTH]) ?
                             '1 : match_cnt_nxt[msc_pkg::OUT_CNT_WIDTH-1:0];
      assign run_tot_nxt   = (|run_cnt_nxt[COUNT_WIDTH-1:msc_pkg::OUT_CNT_WIDTH]) ?
                             '1 : run_cnt_nxt[msc_pkg::OUT_CNT_WIDTH-1:0];
    end else begin : g_extend
      assign match_tot_nxt = msc_pkg::OUT_CNT_WIDTH'(match_cnt_nxt);
      assign run_tot_nxt   = msc_pkg::OUT_CNT_WIDTH'(run_cnt_nxt);
    end
  endgenerate

  msc_cost_select #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_cost_select (
    .match_cnt  (match_cnt_nxt),
    .run_cnt    (run_cnt_nxt),
    .largest_id (largest_id_nxt),
    .seen       (seen_nxt),
    .kind       (kind_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= msc_pkg::MODE_GT;
      thresh_r     <= '0;
      s1_valid_r   <= 1'b0;
      match_cnt_r  <= '0;
      run_cnt_r    <= '0;
      prev_hit_r   <= 1'b0;
      first_id_r   <= '0;
      largest_id_r <= '0;
      seen_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          msc_pkg::REG_COMPARE_MODE:  mode_r   <= cfg_wdata[msc_pkg::MODE_WIDTH-1:0];
          msc_pkg::REG_AGE_THRESHOLD: thresh_r <= cfg_wdata[msc_pkg::AGE_WIDTH-1:0];
          default: ;
        endcase
      end

      if (in_ready) begin
        s1_valid_r <= in_valid;
      end

      if (s1_go) begin
        if (s1_last_r) begin
          match_cnt_r  <= '0;
          run_cnt_r    <= '0;
          prev_hit_r   <= 1'b0;
          first_id_r   <= '0;
          largest_id_r <= '0;
          seen_r       <= 1'b0;
        end else begin
          match_cnt_r  <= match_cnt_nxt;
          run_cnt_r    <= run_cnt_nxt;
          prev_hit_r   <= hit;
          first_id_r   <= first_id_nxt;
          largest_id_r <= largest_id_nxt;
          seen_r       <= seen_nxt;
        end
      end

      if (s1_go && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_id_r   <= in_user_id;
      s1_age_r  <= in_age_days;
      s1_last_r <= in_last_record;
    end
    if (s1_go && s1_last_r) begin
      kind_r        <= kind_nxt;
      match_tot_r   <= match_tot_nxt;
      run_tot_r     <= run_tot_nxt;
      out_first_r   <= seen_nxt ? first_id_nxt : '0;
      out_largest_r <= seen_nxt ? largest_id_nxt : '0;
      out_any_r     <= seen_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_container_kind   = kind_r;
  assign out_match_total      = match_tot_r;
  assign out_run_total        = run_tot_r;
  assign out_first_match_id   = out_first_r;
  assign out_largest_match_id = out_largest_r;
  assign out_any_match        = out_any_r;

  `MSC_ASSERT(a_any_vs_count, clk, rst_n,
    out_valid_r |-> (out_any_r == (match_tot_r != '0)))
  `MSC_ASSERT(a_empty_result, clk, rst_n,
    (out_valid_r && !out_any_r) |-> (kind_r == msc_pkg::KIND_ARRAY &&
      out_first_r == '0 && out_largest_r == '0 && run_tot_r == '0))
  `MSC_ASSERT(a_runs_bounded, clk, rst_n,
    (out_valid_r && out_any_r) |-> (run_tot_r != '0 && run_tot_r <= match_tot_r))
  `MSC_ASSERT(a_last_waits, clk, rst_n,
    (s1_valid_r && s1_last_r && out_valid_r && !out_ready) |=>
      (s1_valid_r && $stable(match_cnt_r) && $stable(run_cnt_r)))

endmodule
